// ===== hdl/two_class_job_queue_top_macros.svh =====
// Assertion macros for the two-class job queue.
// Used by two_class_job_queue_top; no other dependencies.
`ifndef TWO_CLASS_JOB_QUEUE_TOP_MACROS_SVH
`define TWO_CLASS_JOB_QUEUE_TOP_MACROS_SVH

// Property check, reported by $error.
`define TCJQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true at a clock edge.
`define TCJQ_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/tcjq_pkg.sv =====
// Package for the two-class job queue: constants, status codes, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tcjq_pkg;
	localparam int QUEUE_DEPTH = 128;
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] CMD_ENQ    = 3'd0;
	localparam logic [2:0] CMD_DEQ    = 3'd1;
	localparam logic [2:0] CMD_PEEK   = 3'd2;
	localparam logic [2:0] CMD_SEARCH = 3'd3;
	localparam logic [2:0] CMD_CANCEL = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_ID    = 3'd1;
	localparam logic [2:0] ST_DUP       = 3'd2;
	localparam logic [2:0] ST_BAD_PAGES = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_NONE      = 3'd5;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] pages;
	} entry_t;

	typedef struct packed {
		logic        we;
		logic [AW-1:0] waddr;
		entry_t      wdata;
		logic [AW-1:0] raddr;
	} mem_req_t;
endpackage
`default_nettype wire

// ===== hdl/tcjq_store.sv =====
// One job store: single write port, one registered read port.
// Depends on tcjq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcjq_store (
	input  wire                clk,
	input  tcjq_pkg::mem_req_t req,
	output tcjq_pkg::entry_t   rdata
);
	tcjq_pkg::entry_t mem_q [tcjq_pkg::QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata <= mem_q[req.raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/two_class_job_queue_top.sv =====
// Two-class job queue: sequencer over two job stores with one id comparator.
// Depends on tcjq_pkg, tcjq_store and two_class_job_queue_top_macros.svh.
// Enqueue and search walk both queues, priority queue first;
// cancel and a dequeue from the normal queue also shift the rest of that queue.
// One transaction at a time; a result not yet taken holds the sequencer at its last step.
// Asynchronous active-low reset empties both queues and the done count.
`timescale 1ns / 1ps
`default_nettype none
`include "two_class_job_queue_top_macros.svh"
module two_class_job_queue_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// command[2:0], job_id[18:3], page_count[34:19], job_class[35], zeros
	input  wire  [39:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// status[2:0], out_id[18:3], out_pages[34:19], out_class[35],
	// priority_waiting[43:36], normal_waiting[51:44], jobs_done[67:52], zeros
	output logic [71:0] m_tdata
);
	localparam int AW = tcjq_pkg::AW;
	localparam int CW = tcjq_pkg::CW;

	typedef enum logic [3:0] {
		S_IDLE, S_SP_RD, S_SP_CMP, S_SN_RD, S_SN_CMP, S_DECIDE,
		S_HEAD_RD, S_HEAD_WT, S_SH_RD, S_SH_WR, S_OUT
	} state_t;

	state_t state_q;
	logic [2:0]  cmd_q;
	logic [15:0] id_q, pages_q;
	logic        cls_q;
	logic [AW-1:0] ph_q, pt_q;
	logic [CW-1:0] pc_q, nc_q, idx_q;
	logic [15:0] done_q;
	logic        found_q, fcls_q, shq_q;
	logic [AW-1:0] fslot_q, p_q;
	tcjq_pkg::entry_t fent_q;
	logic [2:0]  st_q;
	logic        rep_q;

	tcjq_pkg::mem_req_t preq, nreq;
	tcjq_pkg::entry_t   prd, nrd;

	tcjq_store u_pstore (.clk(clk), .req(preq), .rdata(prd));
	tcjq_store u_nstore (.clk(clk), .req(nreq), .rdata(nrd));

	logic [AW-1:0] p_next, ring_addr;
	logic [CW:0]   ring_sum;
	logic hit;
	assign p_next = (p_q == AW'(tcjq_pkg::QUEUE_DEPTH - 1)) ? '0 : p_q + 1'b1;
	assign ring_sum = (CW+1)'(ph_q) + (CW+1)'(idx_q);
	assign ring_addr = (ring_sum >= (CW+1)'(tcjq_pkg::QUEUE_DEPTH)) ?
		AW'(ring_sum - (CW+1)'(tcjq_pkg::QUEUE_DEPTH)) : AW'(ring_sum);
	assign hit = ((state_q == S_SP_CMP) ? prd.id : nrd.id) == id_q;

	always_comb begin
		preq = '0;
		nreq = '0;
		case (state_q)
			S_SP_RD:   preq.raddr = ring_addr;
			S_SN_RD:   nreq.raddr = AW'(idx_q);
			S_HEAD_RD: begin
				preq.raddr = ph_q;
				nreq.raddr = '0;
			end
			S_SH_RD: begin
				preq.raddr = p_next;
				nreq.raddr = AW'(p_next);
			end
			S_SH_WR: begin
				preq.we = shq_q;
				preq.waddr = p_q;
				preq.wdata = prd;
				nreq.we = !shq_q;
				nreq.waddr = p_q;
				nreq.wdata = nrd;
			end
			S_DECIDE: begin
				if (cmd_q == tcjq_pkg::CMD_ENQ && id_q != '0 && !found_q &&
				    pages_q != '0) begin
					preq.we = cls_q && pc_q != CW'(tcjq_pkg::QUEUE_DEPTH);
					preq.waddr = pt_q;
					preq.wdata = '{id: id_q, pages: pages_q};
					nreq.we = !cls_q && nc_q != CW'(tcjq_pkg::QUEUE_DEPTH);
					nreq.waddr = AW'(nc_q);
					nreq.wdata = '{id: id_q, pages: pages_q};
				end
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q <= '0; pt_q <= '0; pc_q <= '0; nc_q <= '0; done_q <= '0;
			m_tvalid <= 1'b0;
			idx_q <= '0; found_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && state_q != S_OUT) m_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q <= s_tdata[2:0];
						id_q <= s_tdata[18:3];
						pages_q <= s_tdata[34:19];
						cls_q <= s_tdata[35];
						idx_q <= '0;
						found_q <= 1'b0;
						st_q <= tcjq_pkg::ST_OK;
						rep_q <= 1'b0;
						fent_q <= '0;
						fcls_q <= 1'b0;
						case (s_tdata[2:0])
							tcjq_pkg::CMD_ENQ, tcjq_pkg::CMD_SEARCH,
							tcjq_pkg::CMD_CANCEL: state_q <= S_SP_RD;
							tcjq_pkg::CMD_DEQ, tcjq_pkg::CMD_PEEK: state_q <= S_HEAD_RD;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_SP_RD: begin
					if (idx_q == pc_q) begin
						idx_q <= '0;
						state_q <= S_SN_RD;
					end else begin
						fslot_q <= ring_addr;
						state_q <= S_SP_CMP;
					end
				end
				S_SP_CMP: begin
					if (hit) begin
						found_q <= 1'b1; fcls_q <= 1'b1; fent_q <= prd;
						state_q <= S_DECIDE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_SP_RD;
					end
				end
				S_SN_RD: begin
					if (idx_q == nc_q) state_q <= S_DECIDE;
					else begin
						fslot_q <= AW'(idx_q);
						state_q <= S_SN_CMP;
					end
				end
				S_SN_CMP: begin
					if (hit) begin
						found_q <= 1'b1; fcls_q <= 1'b0; fent_q <= nrd;
						state_q <= S_DECIDE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_SN_RD;
					end
				end
				S_DECIDE: begin
					state_q <= S_OUT;
					if (cmd_q == tcjq_pkg::CMD_ENQ) begin
						fent_q <= '0; fcls_q <= 1'b0;
						if (id_q == '0) st_q <= tcjq_pkg::ST_BAD_ID;
						else if (found_q) st_q <= tcjq_pkg::ST_DUP;
						else if (pages_q == '0) st_q <= tcjq_pkg::ST_BAD_PAGES;
						else if (cls_q) begin
							if (pc_q == CW'(tcjq_pkg::QUEUE_DEPTH)) st_q <= tcjq_pkg::ST_FULL;
							else begin
								pt_q <= (pt_q == AW'(tcjq_pkg::QUEUE_DEPTH - 1)) ?
									'0 : pt_q + 1'b1;
								pc_q <= pc_q + 1'b1;
							end
						end else begin
							if (nc_q == CW'(tcjq_pkg::QUEUE_DEPTH)) st_q <= tcjq_pkg::ST_FULL;
							else nc_q <= nc_q + 1'b1;
						end
					end else if (!found_q) begin
						st_q <= tcjq_pkg::ST_NONE;
					end else begin
						rep_q <= 1'b1;
						if (cmd_q == tcjq_pkg::CMD_CANCEL) begin
							shq_q <= fcls_q;
							p_q <= fslot_q;
							state_q <= S_SH_RD;
						end
					end
				end
				S_HEAD_RD: state_q <= S_HEAD_WT;
				S_HEAD_WT: begin
					state_q <= S_OUT;
					if (pc_q != '0) begin
						rep_q <= 1'b1; fcls_q <= 1'b1; fent_q <= prd;
						if (cmd_q == tcjq_pkg::CMD_DEQ) begin
							ph_q <= (ph_q == AW'(tcjq_pkg::QUEUE_DEPTH - 1)) ?
								'0 : ph_q + 1'b1;
							pc_q <= pc_q - 1'b1;
						end
					end else if (nc_q != '0) begin
						rep_q <= 1'b1; fcls_q <= 1'b0; fent_q <= nrd;
						if (cmd_q == tcjq_pkg::CMD_DEQ) begin
							shq_q <= 1'b0;
							p_q <= '0;
							state_q <= S_SH_RD;
						end
					end else st_q <= tcjq_pkg::ST_NONE;
					if ((pc_q != '0 || nc_q != '0) && cmd_q == tcjq_pkg::CMD_DEQ &&
					    done_q != 16'hFFFF)
						done_q <= done_q + 1'b1;
				end
				S_SH_RD: begin
					if (shq_q ? (p_next == pt_q) : ((CW)'(p_q) + 1'b1 >= nc_q)) begin
						if (shq_q) begin
							pt_q <= p_q;
							pc_q <= pc_q - 1'b1;
						end else nc_q <= nc_q - 1'b1;
						state_q <= S_OUT;
					end else state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					p_q <= p_next;
					state_q <= S_SH_RD;
				end
				S_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata <= {4'd0, done_q, 8'(nc_q), 8'(pc_q),
							rep_q & fcls_q, rep_q ? fent_q.pages : 16'd0,
							rep_q ? fent_q.id : 16'd0, st_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TCJQ_NEVER(a_ready_busy, clk, arst_n, s_tready && state_q != S_IDLE, "ready while busy")
	`TCJQ_ASSERT(a_pc_bound, clk, arst_n, pc_q <= CW'(tcjq_pkg::QUEUE_DEPTH), "priority overflow")
	`TCJQ_ASSERT(a_nc_bound, clk, arst_n, nc_q <= CW'(tcjq_pkg::QUEUE_DEPTH), "normal overflow")
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for two_class_job_queue_top: directed and random job commands.
// Depends on tcjq_pkg and the block; predicts each result with its own queue model.
`timescale 1ns / 1ps
module testbench;
	localparam int DEPTH = tcjq_pkg::QUEUE_DEPTH;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic [15:0] done;
		logic [7:0]  nor_n;
		logic [7:0]  pri_n;
		logic        cls;
		logic [15:0] pages;
		logic [15:0] id;
		logic [2:0]  status;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;

	two_class_job_queue_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Shadow queues of the block.
	tcjq_pkg::entry_t pri_q[$];
	tcjq_pkg::entry_t nor_q[$];
	logic [15:0] done_cnt;

	logic [39:0] job_queue[$];
	reply_t      reply_queue[$];
	int  errors;
	int  mismatches;
	int  accepted;
	int  replies;
	int  send_gap;
	int  take_gap;
	bit  hold_off;
	longint cycles = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [39:0] pack_job(logic [2:0] c, logic [15:0] id,
			logic [15:0] pg, logic cl);
		return {4'b0, cl, pg, id, c};
	endfunction

	function automatic int find_id(ref tcjq_pkg::entry_t q[$], input logic [15:0] id);
		foreach (q[i])
			if (q[i].id == id)
				return i;
		return -1;
	endfunction

	function automatic reply_t predict_job(logic [39:0] d);
		reply_t r;
		logic [2:0]  c;
		logic [15:0] id;
		logic [15:0] pg;
		logic        cl;
		tcjq_pkg::entry_t e;
		int k;
		c = d[2:0];
		id = d[18:3];
		pg = d[34:19];
		cl = d[35];
		r = '0;
		r.status = tcjq_pkg::ST_OK;
		case (c)
			tcjq_pkg::CMD_ENQ: begin
				e.id = id;
				e.pages = pg;
				if (id == '0)
					r.status = tcjq_pkg::ST_BAD_ID;
				else if (find_id(pri_q, id) >= 0 || find_id(nor_q, id) >= 0)
					r.status = tcjq_pkg::ST_DUP;
				else if (pg == '0)
					r.status = tcjq_pkg::ST_BAD_PAGES;
				else if (cl) begin
					if (pri_q.size() >= DEPTH)
						r.status = tcjq_pkg::ST_FULL;
					else
						pri_q.push_back(e);
				end else begin
					if (nor_q.size() >= DEPTH)
						r.status = tcjq_pkg::ST_FULL;
					else
						nor_q.push_back(e);
				end
			end
			tcjq_pkg::CMD_DEQ, tcjq_pkg::CMD_PEEK: begin
				if (pri_q.size() != 0) begin
					e = pri_q[0];
					r.cls = 1'b1;
					if (c == tcjq_pkg::CMD_DEQ)
						void'(pri_q.pop_front());
				end else if (nor_q.size() != 0) begin
					e = nor_q[0];
					if (c == tcjq_pkg::CMD_DEQ)
						void'(nor_q.pop_front());
				end else begin
					r.status = tcjq_pkg::ST_NONE;
				end
				if (r.status == tcjq_pkg::ST_OK) begin
					r.id = e.id;
					r.pages = e.pages;
					if (c == tcjq_pkg::CMD_DEQ && done_cnt != 16'hFFFF)
						done_cnt++;
				end
			end
			tcjq_pkg::CMD_SEARCH, tcjq_pkg::CMD_CANCEL: begin
				k = find_id(pri_q, id);
				if (k >= 0) begin
					e = pri_q[k];
					r.cls = 1'b1;
					if (c == tcjq_pkg::CMD_CANCEL)
						pri_q.delete(k);
				end else begin
					k = find_id(nor_q, id);
					if (k >= 0) begin
						e = nor_q[k];
						if (c == tcjq_pkg::CMD_CANCEL)
							nor_q.delete(k);
					end else begin
						r.status = tcjq_pkg::ST_NONE;
					end
				end
				if (r.status == tcjq_pkg::ST_OK) begin
					r.id = e.id;
					r.pages = e.pages;
				end
			end
			default: ;
		endcase
		r.pri_n = 8'(pri_q.size());
		r.nor_n = 8'(nor_q.size());
		r.done = done_cnt;
		return r;
	endfunction

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap <= 0;
			accepted <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				reply_queue.push_back(predict_job(s_tdata));
				accepted <= accepted + 1;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (send_gap > 0) begin
					s_tvalid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (job_queue.size() != 0 && !(hold_off && (reply_queue.size() != 0
						|| (s_tvalid && s_tready)))) begin
					s_tvalid <= 1'b1;
					s_tdata <= job_queue.pop_front();
					send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor.
	always @(posedge clk or negedge arst_n) begin
		reply_t got;
		reply_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			take_gap <= 0;
			errors <= 0;
			mismatches <= 0;
			replies <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[67:0];
				replies <= replies + 1;
				if (reply_queue.size() == 0) begin
					errors <= errors + 1;
					$display("unexpected result %h", m_tdata);
				end else begin
					want = reply_queue.pop_front();
					if (got !== want || m_tdata[71:68] !== 4'b0) begin
						errors <= errors + 1;
						mismatches <= mismatches + 1;
						if (mismatches < 10) begin
							$display("mismatch exp st=%0d id=%h pg=%h cl=%b p=%0d n=%0d d=%0d",
								want.status, want.id, want.pages, want.cls, want.pri_n,
								want.nor_n, want.done);
							$display("         got st=%0d id=%h pg=%h cl=%b p=%0d n=%0d d=%0d",
								got.status, got.id, got.pages, got.cls, got.pri_n,
								got.nor_n, got.done);
						end
					end
				end
			end
			if (take_gap > 0) begin
				m_tready <= 1'b0;
				take_gap <= take_gap - 1;
			end else begin
				m_tready <= 1'b1;
				if (m_tvalid && m_tready)
					take_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout");
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic wait_drained();
		while (job_queue.size() != 0 || s_tvalid || reply_queue.size() != 0)
			@(posedge clk);
	endtask

	// Random traffic: a mix of all commands, unknown codes too, with ids mostly from a pool of 0 to id_span.
	task automatic add_random(int n, int id_span);
		int i;
		logic [2:0]  c;
		logic [15:0] id;
		logic [15:0] pg;
		for (i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: c = tcjq_pkg::CMD_ENQ;
				4, 5: c = tcjq_pkg::CMD_DEQ;
				6: c = tcjq_pkg::CMD_PEEK;
				7: c = tcjq_pkg::CMD_SEARCH;
				8: c = tcjq_pkg::CMD_CANCEL;
				default: c = 3'($urandom_range(0, 7));
			endcase
			id = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, id_span));
			pg = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
			job_queue.push_back(pack_job(c, id, pg, 1'($urandom_range(0, 1))));
		end
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		hold_off = 1'b0;
		done_cnt = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Empty queues, bad id, bad pages, duplicates, order, cancel in the middle.
		job_queue.push_back(pack_job(tcjq_pkg::CMD_DEQ, '0, '0, 1'b0));
		job_queue.push_back(pack_job(tcjq_pkg::CMD_PEEK, '0, '0, 1'b0));
		job_queue.push_back(pack_job(tcjq_pkg::CMD_SEARCH, '0, '0, 1'b0));
		job_queue.push_back(pack_job(tcjq_pkg::CMD_CANCEL, '0, '0, 1'b0));
		job_queue.push_back(pack_job(tcjq_pkg::CMD_ENQ, '0, 16'hFFFF, 1'b1));
		job_queue.push_back(pack_job(tcjq_pkg::CMD_ENQ, 16'hFFFF, '0, 1'b0));
		job_queue.push_back(pack_job(tcjq_pkg::CMD_ENQ, 16'hFFFF, 16'hFFFF, 1'b0));
		job_queue.push_back(pack_job(tcjq_pkg::CMD_ENQ, 16'hFFFF, 16'd5, 1'b1));
		job_queue.push_back(pack_job(tcjq_pkg::CMD_ENQ, 16'd1, 16'd1, 1'b1));
		job_queue.push_back(pack_job(tcjq_pkg::CMD_ENQ, 16'd2, 16'd2, 1'b1));
		job_queue.push_back(pack_job(tcjq_pkg::CMD_ENQ, 16'd3, 16'd3, 1'b1));
		job_queue.push_back(pack_job(tcjq_pkg::CMD_ENQ, 16'd1, 16'd9, 1'b0));
		job_queue.push_back(pack_job(tcjq_pkg::CMD_PEEK, '0, '0, 1'b0));
		job_queue.push_back(pack_job(tcjq_pkg::CMD_SEARCH, 16'hFFFF, '0, 1'b0));
		job_queue.push_back(pack_job(tcjq_pkg::CMD_CANCEL, 16'd2, '0, 1'b0));
		job_queue.push_back(pack_job(tcjq_pkg::CMD_SEARCH, 16'd2, '0, 1'b0));
		job_queue.push_back(pack_job(3'd5, 16'hFFFF, 16'hFFFF, 1'b1));
		job_queue.push_back(pack_job(3'd7, '0, '0, 1'b0));
		for (i = 0; i < 5; i++)
			job_queue.push_back(pack_job(tcjq_pkg::CMD_DEQ, '0, '0, 1'b0));
		wait_drained();

		// Fill both queues to the top, then overflow each, then drain.
		for (i = 1; i <= DEPTH; i++) begin
			job_queue.push_back(pack_job(tcjq_pkg::CMD_ENQ, 16'(i), 16'(i), 1'b1));
			job_queue.push_back(pack_job(tcjq_pkg::CMD_ENQ, 16'(16'h8000 + i),
				16'(16'hFFFF - i), 1'b0));
		end
		job_queue.push_back(pack_job(tcjq_pkg::CMD_ENQ, 16'h7000, 16'd1, 1'b1));
		job_queue.push_back(pack_job(tcjq_pkg::CMD_ENQ, 16'h7001, 16'd1, 1'b0));
		job_queue.push_back(pack_job(tcjq_pkg::CMD_CANCEL, 16'(16'h8000 + DEPTH), '0, 1'b0));
		job_queue.push_back(pack_job(tcjq_pkg::CMD_CANCEL, 16'd64, '0, 1'b0));
		hold_off = 1'b1;
		job_queue.push_back(pack_job(tcjq_pkg::CMD_SEARCH, 16'h8001, '0, 1'b0));
		wait_drained();
		hold_off = 1'b0;
		for (i = 0; i < 2 * DEPTH; i++)
			job_queue.push_back(pack_job(tcjq_pkg::CMD_DEQ, '0, '0, 1'b0));
		add_random(300, 40);
		wait_drained();
		add_random(300, 200);
		add_random(50, 16'hFFFF);
		wait_drained();
		repeat (4 * DEPTH + 20) @(posedge clk);
		$display("Ran %0d transactions with %0d results: fill and overflow of both queues,",
			accepted, replies);
		$display("priority ordering, cancels, bad ids and pages, duplicates, unknown commands.");
		if (errors == 0 && reply_queue.size() == 0 && mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d errors, %0d results outstanding", errors, reply_queue.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
